>>> design/sgmu_pkg.sv
package sgmu_pkg;

    // fixed-point format and sigmoid table geometry
    localparam int FRAC_BITS = 16;
    localparam int TAB_N = 256;
    localparam int TAB_LOG2 = $clog2(TAB_N);
    localparam int SEG_SHIFT = FRAC_BITS + 4 - TAB_LOG2;
    localparam int SIG_W = FRAC_BITS + 1;
    localparam int S_W = SIG_W + 1;
    localparam int PROD_W = 66;
    localparam longint Q30_ONE = 64'sd1 <<< 30;
    localparam longint FX_ONE = 64'sd1 <<< FRAC_BITS;

    typedef logic [SIG_W-1:0] sig_tab_t [0:TAB_N];

    // one input word
    typedef struct packed {
        logic               func;
        logic signed [31:0] gate;
        logic signed [31:0] up;
        logic signed [31:0] upstream_grad;
        logic               last;
    } req_word_t;

    // one result word
    typedef struct packed {
        logic signed [31:0] main_result;
        logic signed [31:0] up_gradient;
        logic               last_out;
    } rsp_word_t;

    // long division of non-negative operands below 2^63, quotient truncated
    function automatic longint quot_nonneg(longint num, longint den);
        longint q;
        longint r;
        int b;
        q = 64'sd0;
        r = 64'sd0;
        for (b = 62; b >= 0; b--)
        begin
            r = (r <<< 1) | ((num >>> b) & 64'sd1);
            if (r >= den)
            begin
                r = r - den;
                q = q | (64'sd1 <<< b);
            end
        end
        return q;
    endfunction

    // exp(-f) in unsigned q30, truncated taylor series
    function automatic longint exp_neg_q30(longint f);
        longint sum;
        longint term;
        int k;
        sum = Q30_ONE;
        term = Q30_ONE;
        for (k = 1; k <= 25; k++)
        begin
            term = quot_nonneg((term * f) >>> 30, longint'(k));
            if (k % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        return (sum < 0) ? 64'sd0 : sum;
    endfunction

    // sigmoid breakpoints over [-8, 8], built at elaboration
    function automatic sig_tab_t build_sig_tab();
        sig_tab_t t;
        longint e1;
        longint n;
        longint a;
        longint mag;
        longint whole;
        longint f;
        longint e;
        longint sn;
        longint w;
        int i;
        e1 = exp_neg_q30(Q30_ONE);
        n = TAB_N;
        for (i = 0; i <= TAB_N; i++)
        begin
            a = 16 * longint'(i) - 8 * n;
            mag = (a < 0) ? -a : a;
            whole = mag >>> TAB_LOG2;
            f = ((mag & (n - 1)) <<< 30) >>> TAB_LOG2;
            e = exp_neg_q30(f);
            for (w = 0; w < whole; w++)
                e = (e * e1 + (64'sd1 <<< 29)) >>> 30;
            sn = quot_nonneg(e <<< 30, Q30_ONE + e);
            sn = (sn + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
            t[i] = SIG_W'((a <= 0) ? sn : (FX_ONE - sn));
        end
        return t;
    endfunction

    localparam sig_tab_t SIG_TAB = build_sig_tab();

endpackage

>>> design/sgmu_round.sv
module sgmu_round (
    input  logic signed [sgmu_pkg::PROD_W-1:0] prod,
    output logic signed [31:0]                 res
);
    import sgmu_pkg::*;

    logic              neg;
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] rnd;
    logic [PROD_W-1:0] sh;
    logic [PROD_W-1:0] lim_pos;

    // round half away from zero on the magnitude, then saturate
    always_comb
    begin
        neg = prod[PROD_W-1];
        mag = neg ? PROD_W'(-prod) : PROD_W'(prod);
        rnd = mag + (PROD_W'(1) << (FRAC_BITS - 1));
        sh = rnd >> FRAC_BITS;
        lim_pos = PROD_W'(32'h7fff_ffff);
        if (neg)
        begin
            if (sh > lim_pos)
                res = 32'sh8000_0000;
            else
                res = -signed'(sh[31:0]);
        end
        else
        begin
            if (sh > lim_pos)
                res = 32'sh7fff_ffff;
            else
                res = signed'(sh[31:0]);
        end
    end

endmodule

>>> design/silu_gated_multiply_unit.sv
// channel | valid     | stall     | word
// request | req_valid | req_stall | req_word (func, gate, up, upstream_grad, last)
// result  | rsp_valid | rsp_stall | rsp_word (main_result, up_gradient, last_out)
//
// nine register stages: sigmoid lookup, interpolation multiply, sigmoid, then three
// rounds of multiply followed by round and saturate; one word per cycle unless rsp_stall holds
// the multipliers are combinational between stage registers
// rst_n clears all stage valid bits asynchronously; payload registers are not reset
// each stage holds only while it is full and the stage after it holds, so bubbles close up
// and rsp_stall reaches req_stall only once every stage is full
module silu_gated_multiply_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  sgmu_pkg::req_word_t req_word,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output sgmu_pkg::rsp_word_t rsp_word
);
    import sgmu_pkg::*;

    localparam int NST = 9;
    localparam int DR_W = S_W + SEG_SHIFT + 1;

    logic [NST:1] v_reg;
    logic [NST:1] v_next;
    logic [NST+1:1] adv;

    // stage advance chain
    always_comb
    begin
        adv[NST+1] = !rsp_stall;
        for (int k = NST; k >= 1; k--)
            adv[k] = !v_reg[k] || adv[k+1];
        v_next = v_reg;
        if (adv[1])
            v_next[1] = req_valid;
        for (int k = 2; k <= NST; k++)
            if (adv[k])
                v_next[k] = v_reg[k-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign req_stall = !adv[1];
    assign rsp_valid = v_reg[NST];

    // stage 1: segment lookup
    logic signed [32:0]         u;
    logic                       lo_next, hi_next;
    logic [TAB_LOG2-1:0]        idx;
    logic [TAB_LOG2:0]          idx1;
    logic [SEG_SHIFT-1:0]       r_next;

    always_comb
    begin
        u = 33'(req_word.gate) + 33'(FX_ONE <<< 3);
        lo_next = u[32];
        hi_next = !u[32] && (u[32:FRAC_BITS+4] != '0);
        idx = u[FRAC_BITS+3:SEG_SHIFT];
        idx1 = {1'b0, idx} + 1'b1;
        r_next = u[SEG_SHIFT-1:0];
    end

    logic                 f1_reg, l1_reg, lo1_reg, hi1_reg;
    logic signed [31:0]   g1_reg, up1_reg, gr1_reg;
    logic [SIG_W-1:0]     t0_1_reg, t1_1_reg;
    logic [SEG_SHIFT-1:0] r1_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            f1_reg <= req_word.func;
            l1_reg <= req_word.last;
            g1_reg <= req_word.gate;
            up1_reg <= req_word.up;
            gr1_reg <= req_word.upstream_grad;
            lo1_reg <= lo_next;
            hi1_reg <= hi_next;
            t0_1_reg <= SIG_TAB[idx];
            t1_1_reg <= SIG_TAB[idx1];
            r1_reg <= r_next;
        end
    end

    // stage 2: slope times remainder
    logic signed [S_W-1:0]  d1;
    logic signed [DR_W-1:0] dr_next;

    always_comb
    begin
        d1 = signed'({1'b0, t1_1_reg}) - signed'({1'b0, t0_1_reg});
        dr_next = DR_W'(d1) * signed'(DR_W'({1'b0, r1_reg}));
    end

    logic                   f2_reg, l2_reg, lo2_reg, hi2_reg;
    logic signed [31:0]     g2_reg, up2_reg, gr2_reg;
    logic [SIG_W-1:0]       t0_2_reg;
    logic signed [DR_W-1:0] dr2_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            f2_reg <= f1_reg;
            l2_reg <= l1_reg;
            g2_reg <= g1_reg;
            up2_reg <= up1_reg;
            gr2_reg <= gr1_reg;
            lo2_reg <= lo1_reg;
            hi2_reg <= hi1_reg;
            t0_2_reg <= t0_1_reg;
            dr2_reg <= dr_next;
        end
    end

    // stage 3: interpolated sigmoid, quotient truncated toward zero
    logic signed [DR_W-1:0] dr_adj;
    logic signed [DR_W-1:0] q;
    logic signed [S_W-1:0]  s_next;

    always_comb
    begin
        dr_adj = dr2_reg + (dr2_reg[DR_W-1] ? DR_W'((1 << SEG_SHIFT) - 1) : DR_W'(0));
        q = dr_adj >>> SEG_SHIFT;
        if (lo2_reg)
            s_next = '0;
        else if (hi2_reg)
            s_next = S_W'(FX_ONE);
        else
            s_next = signed'({1'b0, t0_2_reg}) + q[S_W-1:0];
    end

    logic                  f3_reg, l3_reg;
    logic signed [31:0]    g3_reg, up3_reg, gr3_reg;
    logic signed [S_W-1:0] s3_reg;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            f3_reg <= f2_reg;
            l3_reg <= l2_reg;
            g3_reg <= g2_reg;
            up3_reg <= up2_reg;
            gr3_reg <= gr2_reg;
            s3_reg <= s_next;
        end
    end

    // stage 4: gate*s, gate*(1-s), grad*up
    logic signed [S_W-1:0]    oms;
    logic                     f4_reg, l4_reg;
    logic signed [31:0]       up4_reg, gr4_reg;
    logic signed [S_W-1:0]    s4_reg;
    logic signed [PROD_W-1:0] p_silu4_reg, p_gom4_reg, p_gu4_reg;

    assign oms = S_W'(FX_ONE) - s3_reg;

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            f4_reg <= f3_reg;
            l4_reg <= l3_reg;
            up4_reg <= up3_reg;
            gr4_reg <= gr3_reg;
            s4_reg <= s3_reg;
            p_silu4_reg <= PROD_W'(g3_reg) * PROD_W'(s3_reg);
            p_gom4_reg <= PROD_W'(g3_reg) * PROD_W'(oms);
            p_gu4_reg <= PROD_W'(gr3_reg) * PROD_W'(up3_reg);
        end
    end

    // stage 5: round the first products
    logic signed [31:0] silu_c, gom_c, gu_c;

    sgmu_round u_rnd_silu (.prod(p_silu4_reg), .res(silu_c));
    sgmu_round u_rnd_gom  (.prod(p_gom4_reg),  .res(gom_c));
    sgmu_round u_rnd_gu   (.prod(p_gu4_reg),   .res(gu_c));

    logic                  f5_reg, l5_reg;
    logic signed [31:0]    up5_reg, gr5_reg, silu5_reg, gom5_reg, gu5_reg;
    logic signed [S_W-1:0] s5_reg;

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            f5_reg <= f4_reg;
            l5_reg <= l4_reg;
            up5_reg <= up4_reg;
            gr5_reg <= gr4_reg;
            s5_reg <= s4_reg;
            silu5_reg <= silu_c;
            gom5_reg <= gom_c;
            gu5_reg <= gu_c;
        end
    end

    // stage 6: silu*up, s*(1+gate*(1-s)), grad*silu
    logic signed [33:0]       one_gom;
    logic                     f6_reg, l6_reg;
    logic signed [31:0]       gu6_reg;
    logic signed [PROD_W-1:0] p_fwd6_reg, p_ds6_reg, p_upg6_reg;

    assign one_gom = 34'(gom5_reg) + 34'(FX_ONE);

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            f6_reg <= f5_reg;
            l6_reg <= l5_reg;
            gu6_reg <= gu5_reg;
            p_fwd6_reg <= PROD_W'(silu5_reg) * PROD_W'(up5_reg);
            p_ds6_reg <= PROD_W'(s5_reg) * PROD_W'(one_gom);
            p_upg6_reg <= PROD_W'(gr5_reg) * PROD_W'(silu5_reg);
        end
    end

    // stage 7: round the second products
    logic signed [31:0] fwd_c, ds_c, upg_c;

    sgmu_round u_rnd_fwd (.prod(p_fwd6_reg), .res(fwd_c));
    sgmu_round u_rnd_ds  (.prod(p_ds6_reg),  .res(ds_c));
    sgmu_round u_rnd_upg (.prod(p_upg6_reg), .res(upg_c));

    logic               f7_reg, l7_reg;
    logic signed [31:0] gu7_reg, fwd7_reg, ds7_reg, upg7_reg;

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            f7_reg <= f6_reg;
            l7_reg <= l6_reg;
            gu7_reg <= gu6_reg;
            fwd7_reg <= fwd_c;
            ds7_reg <= ds_c;
            upg7_reg <= upg_c;
        end
    end

    // stage 8: gate gradient product
    logic                     f8_reg, l8_reg;
    logic signed [31:0]       fwd8_reg, upg8_reg;
    logic signed [PROD_W-1:0] p_gg8_reg;

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            f8_reg <= f7_reg;
            l8_reg <= l7_reg;
            fwd8_reg <= fwd7_reg;
            upg8_reg <= upg7_reg;
            p_gg8_reg <= PROD_W'(gu7_reg) * PROD_W'(ds7_reg);
        end
    end

    // stage 9: final round and mode select into the output register
    logic signed [31:0] gg_c;
    rsp_word_t          out_reg;

    sgmu_round u_rnd_gg (.prod(p_gg8_reg), .res(gg_c));

    always_ff @(posedge clk)
    begin
        if (adv[9])
        begin
            out_reg.main_result <= f8_reg ? gg_c : fwd8_reg;
            out_reg.up_gradient <= f8_reg ? upg8_reg : 32'sd0;
            out_reg.last_out <= l8_reg;
        end
    end

    assign rsp_word = out_reg;

    // checks
    a_sig_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[3] |-> (s3_reg >= 0) && (s3_reg <= S_W'(FX_ONE)))
        else $error("sigmoid out of range");

    a_sig_low: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[2] && lo2_reg && adv[3]) |=> (s3_reg == 0))
        else $error("far negative gate gave nonzero sigmoid");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        ((&v_reg) && rsp_stall) |-> req_stall)
        else $error("input taken into a full stalled pipeline");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[8] && !rsp_stall) |=> v_reg[9])
        else $error("word lost at output stage");

    a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (!v_reg[1]) |-> !req_stall)
        else $error("stall with empty first stage");

endmodule

>>> tb/silu_gated_multiply_unit_tb.sv
module silu_gated_multiply_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sgmu_pkg::*;

    localparam int LATENCY = 9;
    localparam int IDLE_LIMIT = 5000;
    localparam longint LIM = 64'sd8 <<< FRAC_BITS;
    localparam longint SPAN = 64'sd16 <<< FRAC_BITS;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_word_t req_word;
    logic rsp_valid;
    logic rsp_stall;
    rsp_word_t rsp_word;

    rsp_word_t pending_words[$];
    longint breakpoints[0:TAB_N];
    int error_count;
    int idle_cycles;
    bit hold_rsp;
    bit steady;

    silu_gated_multiply_unit i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_word(req_word),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_word(rsp_word)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // exp(-f) in unsigned q30 by truncated series
    function automatic longint exp_q30(longint f);
        longint acc;
        longint term;
        acc = Q30_ONE;
        term = Q30_ONE;
        for (int k = 1; k <= 25; k++)
        begin
            term = (term * f) / (longint'(k) * Q30_ONE);
            if (k % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        return (acc < 0) ? 64'sd0 : acc;
    endfunction

    // sigmoid breakpoint table
    task automatic fill_breakpoints();
        longint e1;
        longint a;
        longint mag;
        longint e;
        longint sn;
        e1 = exp_q30(Q30_ONE);
        for (int i = 0; i <= TAB_N; i++)
        begin
            a = 16 * longint'(i) - 8 * longint'(TAB_N);
            mag = (a < 0) ? -a : a;
            e = exp_q30(((mag % TAB_N) <<< 30) / TAB_N);
            for (longint w = 0; w < mag / TAB_N; w++)
                e = (e * e1 + (64'sd1 <<< 29)) >>> 30;
            sn = (e <<< 30) / (Q30_ONE + e);
            sn = (sn + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
            breakpoints[i] = (a <= 0) ? sn : (FX_ONE - sn);
        end
    endtask

    // rounded, saturated fixed-point product
    function automatic longint fx_product(longint a, longint b);
        longint p;
        longint m;
        p = a * b;
        m = (p < 0) ? -p : p;
        m = (m + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (p < 0)
            m = -m;
        if (m > 64'sd2147483647)
            return 64'sd2147483647;
        if (m < -64'sd2147483648)
            return -64'sd2147483648;
        return m;
    endfunction

    // interpolated sigmoid
    function automatic longint sigmoid_of(longint x);
        longint pos;
        longint idx;
        longint rem;
        if (x < -LIM)
            return 0;
        if (x >= LIM)
            return FX_ONE;
        pos = (x + LIM) * TAB_N;
        idx = pos / SPAN;
        rem = pos % SPAN;
        if (idx >= TAB_N)
            return FX_ONE;
        return breakpoints[idx] + ((breakpoints[idx + 1] - breakpoints[idx]) * rem) / SPAN;
    endfunction

    // expected word for one request
    function automatic rsp_word_t swiglu_of(req_word_t w);
        rsp_word_t r;
        longint g;
        longint s;
        longint silu;
        longint dsilu;
        g = longint'(w.gate);
        s = sigmoid_of(g);
        silu = fx_product(g, s);
        r.last_out = w.last;
        if (!w.func)
        begin
            r.main_result = 32'(fx_product(silu, longint'(w.up)));
            r.up_gradient = '0;
        end
        else
        begin
            dsilu = fx_product(s, FX_ONE + fx_product(g, FX_ONE - s));
            r.main_result = 32'(fx_product(
                fx_product(longint'(w.upstream_grad), longint'(w.up)), dsilu));
            r.up_gradient = 32'(fx_product(longint'(w.upstream_grad), silu));
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        error_count++;
    endtask

    // result checker, random stall and watchdog
    initial
    begin
        rsp_word_t want;
        int wait_left;
        rsp_stall <= 1'b1;
        wait_left = 0;
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_words.size() == 0)
                begin
                    report_mismatch("unexpected word", rsp_word.main_result, '0);
                end
                else
                begin
                    want = pending_words.pop_front();
                    if (rsp_word.main_result !== want.main_result)
                        report_mismatch("main_result", rsp_word.main_result, want.main_result);
                    if (rsp_word.up_gradient !== want.up_gradient)
                        report_mismatch("up_gradient", rsp_word.up_gradient, want.up_gradient);
                    if (rsp_word.last_out !== want.last_out)
                        report_mismatch("last_out", 32'(rsp_word.last_out),
                                        32'(want.last_out));
                end
                wait_left = steady ? 0 : $urandom_range(0, 15);
            end
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            if (hold_rsp)
                rsp_stall <= 1'b1;
            else if (wait_left > 0)
            begin
                rsp_stall <= 1'b1;
                wait_left--;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // send one word, predicting its result on acceptance
    task automatic send_word(req_word_t w);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word <= w;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pending_words.push_back(swiglu_of(w));
    endtask

    task automatic end_burst();
        req_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_gate();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
            2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return 32'($signed($urandom_range(0, 16 << 16)) - (8 << 16));
        endcase
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 2))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
            default: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
        endcase
    endfunction

    function automatic req_word_t make_word(logic f, logic [31:0] g, logic [31:0] u,
                                            logic [31:0] d, logic l);
        req_word_t w;
        w.func = f;
        w.gate = g;
        w.up = u;
        w.upstream_grad = d;
        w.last = l;
        return w;
    endfunction

    task automatic wait_drained();
        end_burst();
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    // field extremes, saturating gates, table edges, both modes
    task automatic test_directed();
        logic [31:0] gates[12];
        gates = '{32'h8000_0000, 32'h7fff_ffff, 32'hfff8_0000, 32'hfff7_ffff,
                  32'h0008_0000, 32'h0007_ffff, 32'h0000_0000, 32'h0001_0000,
                  32'hffff_0000, 32'h0000_8000, 32'hfff8_0001, 32'h0000_0001};
        foreach (gates[i])
        begin
            send_word(make_word(1'b0, gates[i], 32'h7fff_ffff, 32'h8000_0000, i[0]));
            send_word(make_word(1'b1, gates[i], 32'h8000_0000, 32'h7fff_ffff, ~i[0]));
        end
        send_word(make_word(1'b1, 32'h0004_0000, 32'h0000_0000, 32'hffff_ffff, 1'b1));
        wait_drained();
    endtask

    // random words with random gaps on both sides
    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_word(make_word(1'($urandom_range(0, 1)), rand_gate(), rand_value(),
                                rand_value(), ($urandom_range(0, 7) == 0)));
    endtask

    // receiver holds off while the sender keeps offering, then a full drain
    task automatic test_backpressure();
        end_burst();
        steady = 1'b1;
        hold_rsp = 1'b1;
        fork
            begin
                repeat (60) @(posedge clk);
                hold_rsp = 1'b0;
            end
            test_random(40);
        join
        steady = 1'b0;
        wait_drained();
    endtask

    // full rate with no gaps
    task automatic test_streaming();
        steady = 1'b1;
        test_random(300);
        steady = 1'b0;
        wait_drained();
    endtask

    initial
    begin
        error_count = 0;
        hold_rsp = 1'b0;
        steady = 1'b0;
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req_word <= '0;
        fill_breakpoints();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(600);
        test_backpressure();
        test_streaming();
        test_random(585);
        wait_drained();
        repeat (LATENCY * 3) @(posedge clk);
        if (error_count == 0 && pending_words.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
